// ===== sv/cpu_load_meter_frame_builder_core_defines.svh =====
// ----------------------------------------------------------------------------
// Load meter frame builder - assertion macros
// Shared property wrappers for the core's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CPU_LOAD_METER_FRAME_BUILDER_CORE_DEFINES_SVH
`define CPU_LOAD_METER_FRAME_BUILDER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define CLM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("load meter check failed");

// next-cycle implication, clocked on clk, quiet during reset
`define CLM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("load meter check failed");

`endif

// ===== sv/clm_pkg.sv =====
// ----------------------------------------------------------------------------
// Load meter package
// Sizes and field widths shared by the load meter frame builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clm_pkg;

	localparam int NUM_PROCESSORS = 16;
	localparam int FRAME_BYTES    = 32;
	localparam int TIME_BITS      = 48;

	localparam int IDX_W  = 6;                       // cpu_index field
	localparam int BIDX_W = 5;                       // byte_index field
	localparam int LOAD_W = 8;                       // meter byte
	localparam int PIDX_W = $clog2(NUM_PROCESSORS);
	localparam int FIDX_W = $clog2(FRAME_BYTES);
	localparam int STEP_W = $clog2(LOAD_W);
	localparam int ACC_W  = TIME_BITS + LOAD_W;      // holds 255 * busy

	localparam int S_DATA_RAW = IDX_W + 2 * TIME_BITS;
	localparam int S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;
	localparam int M_DATA_RAW = BIDX_W + LOAD_W;
	localparam int M_DATA_W   = ((M_DATA_RAW + 7) / 8) * 8;

endpackage

// ===== sv/cpu_load_meter_frame_builder_core.sv =====
// ----------------------------------------------------------------------------
// Load meter frame builder core
// Turns per-processor idle/wall samples into load bytes of a meter frame and
// streams the whole frame out at the end of a sweep that changed it.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                     | tlast
//  s_*     | in  | cpu_index, idle_time, wall_time        | sweep_end
//  m_*     | out | byte_index, byte_value                 | frame_last
//
//  A sample in range passes through two deltas, a repair, a multiply by 255
//  and 8 quotient steps, all through one shared 57-bit subtractor, then the
//  frame write and the sweep decision, before the next tready.
//  A sample outside the processor range goes straight to the sweep decision.
//  A frame goes out byte by byte (single read port of the frame memory),
//  each byte held while m_tready stays low; no sample is taken meanwhile.
//  Reset clears all times and marks every frame byte unwritten (reads as 0).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cpu_load_meter_frame_builder_core_defines.svh"

module cpu_load_meter_frame_builder_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [clm_pkg::S_DATA_W-1:0] s_tdata,  // cpu_index, idle_time, wall_time
	input  logic                         s_tlast,  // sweep_end
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [clm_pkg::M_DATA_W-1:0] m_tdata,  // byte_index, byte_value
	output logic                         m_tlast   // frame_last
);

	import clm_pkg::*;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DIDLE    = 4'd1;
	localparam logic [3:0] ST_DWALL    = 4'd2;
	localparam logic [3:0] ST_FIX      = 4'd3;
	localparam logic [3:0] ST_MUL      = 4'd4;
	localparam logic [3:0] ST_DIV      = 4'd5;
	localparam logic [3:0] ST_WRITE    = 4'd6;
	localparam logic [3:0] ST_FIN      = 4'd7;
	localparam logic [3:0] ST_EMIT_RD  = 4'd8;
	localparam logic [3:0] ST_EMIT_OUT = 4'd9;

	logic [3:0]           state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [TIME_BITS-1:0] idle_q;
	logic [TIME_BITS-1:0] wall_q;
	logic                 last_q;
	logic [TIME_BITS-1:0] di_q;     // idle delta, later busy time
	logic [TIME_BITS-1:0] dw_q;     // wall delta
	logic [ACC_W-1:0]     rem_q;
	logic [ACC_W-1:0]     dsh_q;
	logic [LOAD_W-1:0]    q_q;
	logic                 dzero_q;
	logic [STEP_W-1:0]    step_q;
	logic                 chg_q;
	logic [FIDX_W-1:0]    cnt_q;
	logic [LOAD_W-1:0]    rd_q;

	logic [TIME_BITS-1:0] prev_idle_q [NUM_PROCESSORS];
	logic [TIME_BITS-1:0] prev_wall_q [NUM_PROCESSORS];
	logic                 vld_q       [FRAME_BYTES];
	logic [LOAD_W-1:0]    frame_mem   [FRAME_BYTES];

	logic [IDX_W-1:0]     in_idx;
	logic [TIME_BITS-1:0] in_idle;
	logic [TIME_BITS-1:0] in_wall;
	logic                 in_rng;
	logic [PIDX_W-1:0]    pidx;
	logic [FIDX_W-1:0]    fidx;
	logic [TIME_BITS-1:0] di_fix;
	logic [ACC_W-1:0]     op_a;
	logic [ACC_W-1:0]     op_b;
	logic [ACC_W:0]       diff_w;
	logic                 borrow;
	logic [LOAD_W-1:0]    load;
	logic [LOAD_W-1:0]    old_byte;
	logic [LOAD_W-1:0]    byte_val;
	logic                 mem_we;
	logic                 mem_re;
	logic [FIDX_W-1:0]    mem_raddr;
	logic                 in_hs;

	assign in_idx  = s_tdata[IDX_W-1:0];
	assign in_idle = s_tdata[IDX_W +: TIME_BITS];
	assign in_wall = s_tdata[IDX_W+TIME_BITS +: TIME_BITS];
	assign in_rng  = (in_idx < IDX_W'(NUM_PROCESSORS)) && (in_idx < IDX_W'(FRAME_BYTES));
	assign in_hs   = s_tvalid && s_tready;

	assign pidx   = idx_q[PIDX_W-1:0];
	assign fidx   = idx_q[FIDX_W-1:0];
	assign di_fix = di_q[TIME_BITS-1] ? '0 : di_q;

	// shared subtractor operands
	always_comb begin
		unique case (state_q)
			ST_DIDLE: begin
				op_a = ACC_W'(idle_q);
				op_b = ACC_W'(prev_idle_q[pidx]);
			end
			ST_DWALL: begin
				op_a = ACC_W'(wall_q);
				op_b = ACC_W'(prev_wall_q[pidx]);
			end
			ST_FIX: begin
				op_a = ACC_W'(dw_q);
				op_b = ACC_W'(di_fix);
			end
			ST_MUL: begin
				op_a = {di_q, LOAD_W'(0)};
				op_b = ACC_W'(di_q);
			end
			ST_DIV: begin
				op_a = rem_q;
				op_b = dsh_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign diff_w = {1'b0, op_a} - {1'b0, op_b};
	assign borrow = diff_w[ACC_W];

	assign load     = dzero_q ? '0 : q_q;
	assign old_byte = vld_q[fidx] ? rd_q : '0;
	assign byte_val = vld_q[cnt_q] ? rd_q : '0;

	assign mem_we    = (state_q == ST_WRITE);
	assign mem_re    = ((state_q == ST_IDLE) && s_tvalid) || (state_q == ST_EMIT_RD);
	assign mem_raddr = (state_q == ST_IDLE) ? in_idx[FIDX_W-1:0] : cnt_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[fidx] <= load;
		end
		if (mem_re) begin
			rd_q <= frame_mem[mem_raddr];
		end
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_hs) begin
					idx_q  <= in_idx;
					idle_q <= in_idle;
					wall_q <= in_wall;
				end
			end
			ST_DIDLE: di_q <= diff_w[TIME_BITS-1:0];
			ST_DWALL: dw_q <= diff_w[TIME_BITS-1:0];
			ST_FIX: begin
				// raise a short or negative wall delta to the idle delta
				if (dw_q[TIME_BITS-1] || borrow) begin
					dw_q <= di_fix;
					di_q <= '0;
				end else begin
					di_q <= diff_w[TIME_BITS-1:0];
				end
			end
			ST_MUL: begin
				rem_q   <= diff_w[ACC_W-1:0];
				dsh_q   <= ACC_W'(dw_q) << (LOAD_W - 1);
				dzero_q <= (dw_q == '0);
				q_q     <= '0;
			end
			ST_DIV: begin
				if (!borrow) begin
					rem_q <= diff_w[ACC_W-1:0];
				end
				q_q   <= {q_q[LOAD_W-2:0], !borrow};
				dsh_q <= dsh_q >> 1;
			end
			default: begin
			end
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
			step_q  <= '0;
			chg_q   <= 1'b0;
			cnt_q   <= '0;
			for (int i = 0; i < NUM_PROCESSORS; i++) begin
				prev_idle_q[i] <= '0;
				prev_wall_q[i] <= '0;
			end
			for (int i = 0; i < FRAME_BYTES; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_hs) begin
						last_q  <= s_tlast;
						state_q <= in_rng ? ST_DIDLE : ST_FIN;
					end
				end
				ST_DIDLE: state_q <= ST_DWALL;
				ST_DWALL: begin
					prev_idle_q[pidx] <= idle_q;
					prev_wall_q[pidx] <= wall_q;
					state_q           <= ST_FIX;
				end
				ST_FIX: state_q <= ST_MUL;
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(LOAD_W - 1)) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (load != old_byte) begin
						chg_q <= 1'b1;
					end
					vld_q[fidx] <= 1'b1;
					state_q     <= ST_FIN;
				end
				ST_FIN: begin
					// the change mark lives until the end of the sweep
					if (last_q) begin
						chg_q <= 1'b0;
					end
					cnt_q   <= '0;
					state_q <= (last_q && chg_q) ? ST_EMIT_RD : ST_IDLE;
				end
				ST_EMIT_RD: state_q <= ST_EMIT_OUT;
				ST_EMIT_OUT: begin
					// hold the byte until the request is taken
					if (m_tready) begin
						if (cnt_q == FIDX_W'(FRAME_BYTES - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_EMIT_OUT);
	assign m_tdata  = M_DATA_W'({byte_val, BIDX_W'(cnt_q)});
	assign m_tlast  = (cnt_q == FIDX_W'(FRAME_BYTES - 1));

	`CLM_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready)
	`CLM_ASSERT_NXT(a_gap_between_bytes, m_tvalid && m_tready, !m_tvalid)
	`CLM_ASSERT_NXT(a_ready_after_frame, m_tvalid && m_tready && m_tlast, s_tready)

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Load meter frame builder testbench
// Streams per-processor idle/wall samples into the core and checks every
// emitted meter frame byte against a local model of the load arithmetic,
// under three patterns of sender and receiver back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import clm_pkg::*;

	localparam int DRAIN_CYCLES = 30;   // covers one sample's pass through the core

	typedef logic [TIME_BITS-1:0] tick_t;

	typedef struct {
		logic [BIDX_W-1:0] pos;
		logic [LOAD_W-1:0] level;
		bit                last;
	} meter_byte_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;   // cpu_index, idle_time, wall_time
	logic                s_tlast = 1'b0; // sweep_end
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;        // byte_index, byte_value
	logic                m_tlast;        // frame_last

	// model of the core's state
	tick_t             last_idle [NUM_PROCESSORS];
	tick_t             last_wall [NUM_PROCESSORS];
	logic [LOAD_W-1:0] meter_level [FRAME_BYTES];
	bit                meter_dirty;

	meter_byte_t frame_bytes_due [$];

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int n_samples      = 0;
	int n_frames       = 0;
	int n_bytes        = 0;

	cpu_load_meter_frame_builder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// load = floor(255 * busy / wall) on repaired deltas
	function automatic logic [LOAD_W-1:0] busy_level(tick_t idle_now, tick_t wall_now,
			tick_t idle_was, tick_t wall_was);
		tick_t            d_idle;
		tick_t            d_wall;
		longint unsigned  busy;
		longint unsigned  span;
		d_idle = idle_now - idle_was;
		d_wall = wall_now - wall_was;
		if (d_idle[TIME_BITS-1])
			d_idle = '0;
		if (d_wall[TIME_BITS-1] || d_wall < d_idle)
			d_wall = d_idle;
		if (d_wall == '0)
			return '0;
		span = longint'(d_wall);
		busy = span - longint'(d_idle);
		return LOAD_W'((busy * 255) / span);
	endfunction

	task automatic update_meter_model(logic [IDX_W-1:0] idx, tick_t idle, tick_t wall, bit last);
		logic [LOAD_W-1:0] level;
		meter_byte_t       b;
		if (idx < NUM_PROCESSORS && idx < FRAME_BYTES) begin
			level = busy_level(idle, wall, last_idle[idx], last_wall[idx]);
			if (meter_level[idx] != level) begin
				meter_level[idx] = level;
				meter_dirty = 1'b1;
			end
			last_idle[idx] = idle;
			last_wall[idx] = wall;
		end
		if (last) begin
			if (meter_dirty) begin
				for (int k = 0; k < FRAME_BYTES; k++) begin
					b.pos = BIDX_W'(k);
					b.level = meter_level[k];
					b.last = (k == FRAME_BYTES - 1);
					frame_bytes_due.push_back(b);
				end
				n_frames++;
			end
			meter_dirty = 1'b0;
		end
	endtask

	task automatic send_sample(logic [IDX_W-1:0] idx, tick_t idle, tick_t wall, bit last);
		logic [S_DATA_W-1:0] word;
		word = '0;
		word[IDX_W-1:0] = idx;
		word[IDX_W +: TIME_BITS] = idle;
		word[IDX_W + TIME_BITS +: TIME_BITS] = wall;
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		update_meter_model(idx, idle, wall, last);
		n_samples++;
	endtask

	// hold the sender until the frame queue is empty and the core has settled
	task automatic drain_frames();
		s_tvalid <= 1'b0;
		while (frame_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		meter_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_bytes++;
			if (frame_bytes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected frame byte: index %0d value %0d last %0b",
						m_tdata[BIDX_W-1:0], m_tdata[BIDX_W +: LOAD_W], m_tlast);
			end else begin
				want = frame_bytes_due.pop_front();
				if (m_tdata[BIDX_W-1:0] !== want.pos || m_tdata[BIDX_W +: LOAD_W] !== want.level
						|| m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("frame byte mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
							want.pos, want.level, want.last, m_tdata[BIDX_W-1:0],
							m_tdata[BIDX_W +: LOAD_W], m_tlast);
				end
			end
		end
	end

	task automatic test_directed_cases();
		send_gap_pct = 10;
		recv_stall_pct = 87;
		send_sample(6'd0, 48'd0, 48'd0, 1'b1);              // zero wall delta, nothing changed
		send_sample(6'd0, 48'd100, 48'd200, 1'b0);
		send_sample(6'd15, 48'd0, 48'd1000, 1'b0);
		send_sample(6'd16, 48'd5, 48'd5, 1'b1);             // out of range, sweep mark still acts
		send_sample(6'd0, 48'd50, 48'd300, 1'b1);           // idle went backwards
		send_sample(6'd1, 48'd500, 48'd100, 1'b0);          // wall delta below idle delta
		send_sample(6'd2, 48'd10, 48'hFFFF_FFFF_FFFB, 1'b1); // wall went backwards
		send_sample(6'd2, 48'd10, 48'd5, 1'b1);             // wall wraps forward
		send_sample(6'd2, 48'd10, 48'd5, 1'b1);
		send_sample(6'd2, 48'd10, 48'd5, 1'b1);             // sweep end with no change
		send_sample(6'd63, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
		send_sample(6'd3, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
		send_sample(6'd4, 48'd0, 48'h7FFF_FFFF_FFFF, 1'b0);
		send_sample(6'd5, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b0);
		send_sample(6'd6, 48'd1, 48'h7FFF_FFFF_FFFF, 1'b0);
		send_sample(6'd7, 48'd1, 48'd3, 1'b1);
		send_sample(6'd31, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b1);
		send_sample(6'd15, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b1);
		drain_frames();
	endtask

	task automatic test_sweeps(int n_items, int gap_pct, int stall_pct);
		int          sent;
		int          len;
		int          start;
		int          cpu;
		tick_t       d_wall;
		tick_t       d_idle;
		longint      scale;
		sent = 0;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		while (sent < n_items) begin
			if ($urandom_range(99) < 20) begin
				// noise: any index, raw times, random sweep mark
				send_sample(IDX_W'($urandom_range(63)), tick_t'({$urandom, $urandom}),
					tick_t'({$urandom, $urandom}), ($urandom_range(99) < 30));
				sent++;
			end else begin
				len = $urandom_range(1, NUM_PROCESSORS);
				start = $urandom_range(NUM_PROCESSORS - 1);
				for (int k = 0; k < len; k++) begin
					cpu = (start + k) % NUM_PROCESSORS;
					case ($urandom_range(9))
						0:       d_wall = '0;
						1, 2:    d_wall = tick_t'({$urandom, $urandom}) & 48'h7FFF_FFFF_FFFF;
						default: d_wall = tick_t'($urandom_range(1, 1 << 20));
					endcase
					scale = $urandom_range(0, 256);
					d_idle = tick_t'((longint'(d_wall) * scale) >> 8);
					if ($urandom_range(19) == 0)
						d_idle = d_wall + tick_t'($urandom_range(1, 1000));
					send_sample(IDX_W'(cpu), last_idle[cpu] + d_idle, last_wall[cpu] + d_wall,
						(k == len - 1));
					sent++;
				end
			end
			if (sent >= n_items / 2 && sent < n_items / 2 + 4 && $urandom_range(1) == 1)
				drain_frames();
		end
		drain_frames();
	endtask

	initial begin
		int wait_cycles;
		for (int i = 0; i < NUM_PROCESSORS; i++) begin
			last_idle[i] = '0;
			last_wall[i] = '0;
		end
		for (int i = 0; i < FRAME_BYTES; i++)
			meter_level[i] = '0;
		meter_dirty = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_sweeps(95, 10, 87);
		test_sweeps(95, 87, 10);
		test_sweeps(100, 0, 0);

		s_tvalid <= 1'b0;
		wait_cycles = 0;
		while (frame_bytes_due.size() != 0 && wait_cycles < 50000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (frame_bytes_due.size() != 0) begin
			mismatches += frame_bytes_due.size();
			$display("%0d frame bytes never arrived", frame_bytes_due.size());
		end

		$display("ran %0d samples through directed and random sweeps", n_samples);
		$display("checked %0d frames, %0d bytes, %0d mismatches", n_frames, n_bytes, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
